[design/polar_segment_stepper_top_macros.svh]
// Assertion macros shared by the polar segment stepper modules.
// Each expects clk and rst_n in scope where it is used.
`ifndef POLAR_SEGMENT_STEPPER_TOP_MACROS_SVH
`define POLAR_SEGMENT_STEPPER_TOP_MACROS_SVH

// Property holds in the same cycle as its antecedent.
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property holds in the cycle after its antecedent.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pss_pkg.sv]
// Package for the polar segment stepper: payload structs, command struct,
// fixed-point widths, constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  localparam int OP_W    = 2;
  localparam int LEN_W   = 24;
  localparam int ANG_W   = 16;
  localparam int COORD_W = 32;
  localparam int GAIN_W  = 30;
  localparam int PROD_W  = LEN_W + GAIN_W;
  localparam int XY_W    = 44;
  localparam int ATAN_W  = 30;
  localparam int Z_SHIFT = 17;
  localparam int Z_W     = 34;
  localparam int X0_SHIFT = 14;
  localparam int RND_SHIFT = 16;

  localparam logic [OP_W-1:0] OP_ORIGIN   = 2'd0;
  localparam logic [OP_W-1:0] OP_CONTINUE = 2'd1;
  localparam logic [OP_W-1:0] OP_GIVEN    = 2'd2;

  localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [GAIN_W-1:0]       GAIN_Q30    = 30'h26DD3B6A;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [LEN_W-1:0]          length;
    logic signed [ANG_W-1:0]   angle;
    logic                      reuse_angle;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
  } pss_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      saturated;
  } pss_out_t;

  typedef struct packed {
    logic                  load;
    logic                  mult;
    logic                  step;
    logic [STEP_IDX_W-1:0] step_idx;
    logic                  round;
    logic                  finish;
  } pss_cmd_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/pss_ctrl.sv]
// Controller for the polar segment stepper: sequences load, gain multiply,
// CORDIC iterations, rounding and result write. Depends on pss_pkg and the macros header.
`timescale 1ns / 1ps
`include "polar_segment_stepper_top_macros.svh"

module pss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pss_pkg::pss_cmd_t cmd
);
  import pss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULT = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [STEP_IDX_W-1:0] LAST_STEP = STEP_IDX_W'(CORDIC_STEPS - 1);

  logic [2:0]            state_r, state_nxt;
  logic [STEP_IDX_W-1:0] step_cnt_r, step_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.step_idx  = step_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult     = 1'b1;
        step_cnt_nxt = '0;
        state_nxt    = S_ITER;
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (step_cnt_r == LAST_STEP) begin
          state_nxt = S_RND;
        end else begin
          step_cnt_nxt = step_cnt_r + 1'b1;
        end
      end
      S_RND: begin
        cmd.round = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Wait here until the output register can take the new result.
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PSS_ASSERT_NEXT(a_accept_to_mult, in_valid && in_ready, state_r == S_MULT,
                   "accepted transaction did not start the multiply")
  `PSS_ASSERT_NOW(a_finish_free, cmd.finish, !out_valid_r || out_ready,
                  "result written over an untaken result")
  `PSS_ASSERT_NEXT(a_iter_count, state_r == S_ITER && step_cnt_r != LAST_STEP,
                   state_r == S_ITER && step_cnt_r == $past(step_cnt_r) + 1'b1,
                   "CORDIC step counter skipped")

endmodule

[design/pss_datapath.sv]
// Datapath for the polar segment stepper: start point and angle selection,
// gain multiply, shared CORDIC step unit, rounding, saturating add. Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  pss_pkg::pss_cmd_t cmd,
  input  pss_pkg::pss_in_t  in_data,
  output pss_pkg::pss_out_t out_data
);
  import pss_pkg::*;

  logic signed [COORD_W-1:0] last_end_x_r, last_end_y_r;
  logic signed [ANG_W-1:0]   stored_angle_r;

  logic signed [COORD_W-1:0] start_x_r, start_y_r;
  logic [LEN_W-1:0]          len_r;
  logic                      neg_r;
  logic signed [Z_W-1:0]     z_r;
  logic signed [XY_W-1:0]    x_r, y_r;
  logic signed [COORD_W-1:0] dx_r, dy_r;
  pss_out_t                  out_r;

  // Load: angle select and fold into [-pi/2, pi/2].
  logic signed [ANG_W-1:0] ang_sel, ang_fold;
  logic                    fold_neg;

  always_comb begin
    if (in_data.op != OP_ORIGIN && in_data.reuse_angle) begin
      ang_sel = stored_angle_r;
    end else begin
      ang_sel = in_data.angle;
    end
    fold_neg = 1'b0;
    ang_fold = ang_sel;
    if (ang_sel > HALF_PI_Q13) begin
      ang_fold = ang_sel - PI_Q13;
      fold_neg = 1'b1;
    end else if (ang_sel < -HALF_PI_Q13) begin
      ang_fold = ang_sel + PI_Q13;
      fold_neg = 1'b1;
    end
  end

  // Gain multiply with rounding into units of 2^-16.
  logic [PROD_W-1:0] prod_rnd;
  assign prod_rnd = PROD_W'(len_r) * PROD_W'(GAIN_Q30) + PROD_W'(1 << (X0_SHIFT - 1));

  // Shared CORDIC step.
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atan_z;
  assign xs     = x_r >>> cmd.step_idx;
  assign ys     = y_r >>> cmd.step_idx;
  assign atan_z = Z_W'(atan_q30(ATAN_IDX_W'(cmd.step_idx)));

  // Sign restore and round to integer coordinates (Q.0).
  logic signed [XY_W-1:0] vx, vy, rx, ry;
  always_comb begin
    vx = neg_r ? -x_r : x_r;
    vy = neg_r ? -y_r : y_r;
    rx = (vx + XY_W'(1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
    ry = (vy + XY_W'(1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
  end

  // Saturating add of offset to start point.
  logic signed [COORD_W:0]   sum_x, sum_y;
  logic signed [COORD_W-1:0] end_x, end_y;
  logic                      sat_x, sat_y;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  always_comb begin
    sum_x = {start_x_r[COORD_W-1], start_x_r} + {dx_r[COORD_W-1], dx_r};
    sum_y = {start_y_r[COORD_W-1], start_y_r} + {dy_r[COORD_W-1], dy_r};
    sat_x = sum_x[COORD_W] != sum_x[COORD_W-1];
    sat_y = sum_y[COORD_W] != sum_y[COORD_W-1];
    if (!sat_x) begin
      end_x = sum_x[COORD_W-1:0];
    end else begin
      end_x = sum_x[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    if (!sat_y) begin
      end_y = sum_y[COORD_W-1:0];
    end else begin
      end_y = sum_y[COORD_W] ? COORD_MIN : COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_end_x_r   <= '0;
      last_end_y_r   <= '0;
      stored_angle_r <= '0;
    end else begin
      if (cmd.load && in_data.op != OP_ORIGIN && !in_data.reuse_angle) begin
        stored_angle_r <= in_data.angle;
      end
      if (cmd.finish) begin
        last_end_x_r <= end_x;
        last_end_y_r <= end_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r <= in_data.length;
      neg_r <= fold_neg;
      z_r   <= {{(Z_W-ANG_W-Z_SHIFT){ang_fold[ANG_W-1]}}, ang_fold, {Z_SHIFT{1'b0}}};
      case (in_data.op)
        OP_ORIGIN: begin
          start_x_r <= '0;
          start_y_r <= '0;
        end
        OP_CONTINUE: begin
          start_x_r <= last_end_x_r;
          start_y_r <= last_end_y_r;
        end
        default: begin
          start_x_r <= in_data.origin_x;
          start_y_r <= in_data.origin_y;
        end
      endcase
    end
    if (cmd.mult) begin
      x_r <= XY_W'(prod_rnd[PROD_W-1:X0_SHIFT]);
      y_r <= '0;
    end
    if (cmd.step) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_z;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_z;
      end
    end
    if (cmd.round) begin
      dx_r <= rx[COORD_W-1:0];
      dy_r <= ry[COORD_W-1:0];
    end
    if (cmd.finish) begin
      out_r.start_x   <= start_x_r;
      out_r.start_y   <= start_y_r;
      out_r.end_x     <= end_x;
      out_r.end_y     <= end_y;
      out_r.saturated <= sat_x || sat_y;
    end
  end

  assign out_data = out_r;

endmodule

[design/polar_segment_stepper_top.sv]
// A result is valid after its input transaction has passed the load, multiply, CORDIC
// iteration, round and finish states; a new transaction is taken only when idle, and
// the single shared CORDIC step unit iterates once per cycle.
// A pending result waits in the output register; the next transaction is taken meanwhile.
// Reset (rst_n, synchronous): last end point and stored angle clear to zero.
`timescale 1ns / 1ps

module polar_segment_stepper_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pss_pkg::pss_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pss_pkg::pss_out_t out_data
);
  import pss_pkg::*;

  pss_cmd_t cmd;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pss_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for polar_segment_stepper_top: directed segments, then random ones,
// with each result checked against a behavioral CORDIC predictor in this file or a hand-typed result.
// Depends on pss_pkg for payload types and opcodes; needs nothing but the RTL.
`timescale 1ns / 1ps

module testbench;
  import pss_pkg::*;

  localparam logic [OP_W-1:0] OP_GIVEN_ALIAS = 2'd3;
  localparam int RANDOM_SEGMENTS = 1250;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 400;
  localparam longint CORDIC_GAIN = 652032874;
  localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

  typedef struct {
    pss_in_t  stim;
    bit       pinned;
    pss_out_t result;
  } step_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pss_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pss_out_t out_data;

  // Hand-typed result for the segment currently offered, when there is one.
  logic     pin_active;
  pss_out_t pin_result;

  logic signed [COORD_W-1:0] pen_x;
  logic signed [COORD_W-1:0] pen_y;
  logic signed [ANG_W-1:0]   pen_angle;

  pss_out_t  pending_segments[$];
  step_row_t directed_rows[$];
  pss_out_t  predicted;
  pss_out_t  want;
  int        mismatches;
  int        results_seen;
  int        segments_sent;
  int        saturated_seen;
  int        op_count[4];

  polar_segment_stepper_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint arctan_q30(input int idx);
    case (idx)
      0:  return 64'h3243F6A8;
      1:  return 64'h1DAC6705;
      2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;
      4:  return 64'h03FEAB76;
      5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;
      7:  return 64'h007FFF55;
      8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      23: return 64'h0000007F;
      default: return 64'h0;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v, inout bit sat);
    if (v > longint'(COORD_MAX)) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  // Computes one segment and advances the pen position and the held angle.
  function automatic pss_out_t plot_segment(input pss_in_t item);
    pss_out_t                  seg_out;
    logic signed [ANG_W-1:0]   ang;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    longint                    a, x, y, z, xs, ys;
    bit                        flip;
    bit                        sat;
    int                        steps;
    ang = item.angle;
    flip = 1'b0;
    sat = 1'b0;
    if (item.op == OP_ORIGIN) begin
      seg_out.start_x = '0;
      seg_out.start_y = '0;
    end else begin
      if (item.reuse_angle) begin
        ang = pen_angle;
      end else begin
        pen_angle = item.angle;
      end
      if (item.op == OP_CONTINUE) begin
        seg_out.start_x = pen_x;
        seg_out.start_y = pen_y;
      end else begin
        seg_out.start_x = item.origin_x;
        seg_out.start_y = item.origin_y;
      end
    end
    a = ang;
    // Fold into the right half-plane and flip the vector back at the end.
    if (a > longint'(HALF_PI_Q13)) begin
      a = a - longint'(PI_Q13);
      flip = 1'b1;
    end else if (a < -longint'(HALF_PI_Q13)) begin
      a = a + longint'(PI_Q13);
      flip = 1'b1;
    end
    z = a * 131072;
    x = (longint'(item.length) * CORDIC_GAIN + 8192) >>> 14;
    y = 0;
    steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q30(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q30(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    off_x = COORD_W'((x + 32768) >>> 16);
    off_y = COORD_W'((y + 32768) >>> 16);
    seg_out.end_x = clamp_coord(longint'(seg_out.start_x) + longint'(off_x), sat);
    seg_out.end_y = clamp_coord(longint'(seg_out.start_y) + longint'(off_y), sat);
    seg_out.saturated = sat;
    pen_x = seg_out.end_x;
    pen_y = seg_out.end_y;
    return seg_out;
  endfunction

  function automatic pss_in_t seg(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                                  input logic signed [ANG_W-1:0] ang, input logic reuse,
                                  input logic signed [COORD_W-1:0] ox,
                                  input logic signed [COORD_W-1:0] oy);
    pss_in_t item;
    item.op = op;
    item.length = len;
    item.angle = ang;
    item.reuse_angle = reuse;
    item.origin_x = ox;
    item.origin_y = oy;
    return item;
  endfunction

  function automatic pss_out_t fixed_result(input logic signed [COORD_W-1:0] sx,
                                            input logic signed [COORD_W-1:0] sy);
    pss_out_t r;
    r.start_x = sx;
    r.start_y = sy;
    r.end_x = sx;
    r.end_y = sy;
    r.saturated = 1'b0;
    return r;
  endfunction

  task automatic add_row(input pss_in_t stim, input bit pinned, input pss_out_t r);
    step_row_t row;
    row.stim = stim;
    row.pinned = pinned;
    row.result = r;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Mostly chains of continued segments, mixed with restarts and given start points.
  function automatic pss_in_t random_segment();
    pss_in_t item;
    int      pick;
    item.origin_x = $urandom;
    item.origin_y = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      item.op = OP_CONTINUE;
    end else if (pick < 75) begin
      item.op = OP_ORIGIN;
    end else if (pick < 92) begin
      item.op = OP_GIVEN;
    end else begin
      item.op = OP_GIVEN_ALIAS;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      item.length = LEN_W'($urandom);
    end else if (pick < 9) begin
      item.length = LEN_W'($urandom_range(0, 65535));
    end else begin
      item.length = LEN_W'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < 85) begin
      item.angle = ANG_W'($signed($urandom_range(0, 2 * 25736)) - 25736);
    end else begin
      item.angle = ANG_W'($urandom);
    end
    item.reuse_angle = ($urandom_range(0, 9) < 3);
    if (item.op != OP_CONTINUE && item.op != OP_ORIGIN) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        item.origin_x = COORD_MAX - $signed($urandom_range(0, 1 << 24));
      end else if (pick == 1) begin
        item.origin_y = COORD_MIN + $signed($urandom_range(0, 1 << 24));
      end
    end
    return item;
  endfunction

  task automatic send_segment(input pss_in_t item, input bit pinned, input pss_out_t r);
    int gap;
    gap = (((segments_sent / 150) % 3) == 2) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= item;
    pin_active <= pinned;
    pin_result <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    segments_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] exp_v,
                             input logic [COORD_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(exp_v), $signed(got_v));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = plot_segment(in_data);
        if (pin_active) begin
          predicted = pin_result;
        end
        pending_segments.insert(pending_segments.size(), predicted);
        op_count[in_data.op]++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_segments.size() == 0) begin
          $display("%0t ns: unexpected segment, expected none, actual start (%0d,%0d)",
                   $time, out_data.start_x, out_data.start_y);
          mismatches++;
        end else begin
          want = pending_segments.pop_front();
          check_field("start_x", want.start_x, out_data.start_x);
          check_field("start_y", want.start_y, out_data.start_y);
          check_field("end_x", want.end_x, out_data.end_x);
          check_field("end_y", want.end_y, out_data.end_y);
          check_field("saturated", COORD_W'(want.saturated), COORD_W'(out_data.saturated));
          if (want.saturated) begin
            saturated_seen++;
          end
        end
      end
    end
  end

  // Result side: random stalls, some stall-free stretches, and one long hold-off so
  // that the block backs up into its input.
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = (((results_seen / 170) % 3) == 1) ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout waiting for segments.");
    $display("polar_segment_stepper_top regression: fail");
    $finish;
  end

  initial begin
    pss_out_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    pin_active = 1'b0;
    pin_result = '0;
    pen_x = '0;
    pen_y = '0;
    pen_angle = '0;
    mismatches = 0;
    results_seen = 0;
    segments_sent = 0;
    saturated_seen = 0;
    op_count = '{0, 0, 0, 0};

    // Continue straight after reset starts from the cleared end point.
    add_row(seg(OP_CONTINUE, 24'd0, 16'sd0, 1'b0, 32'sd0, 32'sd0), 1'b1, fixed_result(0, 0));
    add_row(seg(OP_ORIGIN, LEN_MAX, 16'sd0, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_ORIGIN, LEN_MAX, PI_Q13, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_ORIGIN, LEN_MAX, -PI_Q13, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_CONTINUE, LEN_MAX, HALF_PI_Q13, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_CONTINUE, LEN_MAX, -HALF_PI_Q13, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_CONTINUE, 24'd1000, HALF_PI_Q13 + 16'sd1, 1'b0, 32'sd0, 32'sd0),
            1'b0, none);
    add_row(seg(OP_CONTINUE, 24'd1000, -HALF_PI_Q13 - 16'sd1, 1'b0, 32'sd0, 32'sd0),
            1'b0, none);
    add_row(seg(OP_CONTINUE, 24'h012345, 16'sd0, 1'b1, 32'sd0, 32'sd0), 1'b0, none);
    // A restart at the origin ignores the reuse flag and leaves the held angle alone.
    add_row(seg(OP_ORIGIN, 24'h000100, 16'sd3000, 1'b1, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_CONTINUE, 24'h000100, 16'sd7000, 1'b1, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_GIVEN, LEN_MAX, 16'sd0, 1'b0, COORD_MAX, COORD_MAX), 1'b0, none);
    add_row(seg(OP_GIVEN, LEN_MAX, PI_Q13, 1'b0, COORD_MIN, COORD_MIN), 1'b0, none);
    add_row(seg(OP_GIVEN, LEN_MAX, HALF_PI_Q13, 1'b0, 32'sd0, COORD_MAX), 1'b0, none);
    add_row(seg(OP_GIVEN_ALIAS, 24'h00ABCD, -16'sd5000, 1'b0, 32'sh12345678,
                -32'sh00ABCDEF), 1'b0, none);
    add_row(seg(OP_GIVEN_ALIAS, 24'h000800, 16'sd0, 1'b1, -100, 200), 1'b0, none);
    add_row(seg(OP_ORIGIN, 24'h004000, 16'sh7FFF, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_ORIGIN, 24'h004000, 16'sh8000, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_GIVEN, 24'd0, 16'sd1234, 1'b0, COORD_MAX, COORD_MIN), 1'b1,
            fixed_result(COORD_MAX, COORD_MIN));
    add_row(seg(OP_ORIGIN, 24'd0, -16'sd1234, 1'b1, COORD_MIN, COORD_MAX), 1'b1,
            fixed_result(0, 0));
    add_row(seg(OP_CONTINUE, 24'd1, 16'sd1, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_CONTINUE, LEN_MAX, 16'sh8000, 1'b0, 32'sd0, 32'sd0), 1'b0, none);
    add_row(seg(OP_CONTINUE, 24'h800000, 16'sd0, 1'b1, 32'sd0, 32'sd0), 1'b0, none);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_segment(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].result);
    end
    repeat (RANDOM_SEGMENTS) begin
      send_segment(random_segment(), 1'b0, none);
    end
    in_valid <= 1'b0;
    pin_active <= 1'b0;

    while (pending_segments.size() != 0) @(posedge clk);
    repeat (3 * (CORDIC_STEPS + 4)) @(posedge clk);

    $display("Covered %0d segments: %0d origin, %0d continue, %0d given point, %0d op 3.",
             segments_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d results checked, %0d saturated, one %0d-cycle output stall.",
             results_seen, saturated_seen, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("polar_segment_stepper_top regression: pass");
    end else begin
      $display("polar_segment_stepper_top regression: fail");
    end
    $finish;
  end

endmodule

[polar_segment_stepper_top.f]
+incdir+design
design/pss_pkg.sv
design/pss_ctrl.sv
design/pss_datapath.sv
design/polar_segment_stepper_top.sv
tb/testbench.sv
